FILE: rtl/core/sha1d_pkg.sv
// Shared types, constants and state encodings of the SHA-1 digest block.
`default_nettype none

package sha1d_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] blk_t;
  typedef word_t [4:0]  chain_t;

  // Initial chaining value, word 0 in the lowest slot
  localparam chain_t ChainInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

  // Round constants
  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [6:0] LastRound = 7'd79;

  // Byte positions inside a 64-byte block
  localparam logic [5:0] LastBytePos = 6'd63;
  localparam logic [5:0] LenBytePos  = 6'd56;
  localparam logic [7:0] PadByte     = 8'h80;

  // Digest word index of the final output beat
  localparam logic [2:0] LastIdx = 3'd4;

  // Queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } ent_t;

  typedef struct packed {
    logic start;
    logic init;
  } core_ctrl_t;

  typedef struct packed {
    logic   busy;
    chain_t chain;
  } core_stat_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RUN,
    CS_ADD
  } core_st_e;

  typedef enum logic [2:0] {
    BS_ABSORB,
    BS_PAD,
    BS_LEN,
    BS_FIN,
    BS_OUT
  } back_st_e;

endpackage

`default_nettype wire

FILE: rtl/core/sha1d_front.sv
// Input stage: takes stream beats, drops empty ones, hands the rest to the queue.
`default_nettype none

module sha1d_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,  // [7:0] data_byte
  input  logic              s_axis_tuser_i,  // [0] has_byte
  input  logic              s_axis_tlast_i,  // end_of_message
  output logic              push_o,
  output sha1d_pkg::ent_t   push_data_o,
  input  logic              push_ready_i
);
  import sha1d_pkg::*;

  logic valid_q, valid_d;
  ent_t ent_q, ent_d;
  logic accept, keep, pushing;

  // Classify the beat: one with neither byte nor end changes nothing
  always_comb begin
    pushing = valid_q && push_ready_i;
    s_axis_tready_o = !valid_q || push_ready_i;
    accept = s_axis_tvalid_i && s_axis_tready_o;
    keep = s_axis_tuser_i || s_axis_tlast_i;
    valid_d = valid_q;
    ent_d = ent_q;
    if (pushing) begin
      valid_d = 1'b0;
    end
    if (accept && keep) begin
      valid_d = 1'b1;
      ent_d.data = s_axis_tdata_i;
      ent_d.has_byte = s_axis_tuser_i;
      ent_d.eom = s_axis_tlast_i;
    end
  end

  // Hold the staged entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign push_o = valid_q;
  assign push_data_o = ent_q;

endmodule

`default_nettype wire

FILE: rtl/core/sha1d_fifo.sv
// Short entry queue between the input stage and the block sequencer.
`default_nettype none

module sha1d_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sha1d_pkg::ent_t push_data_i,
  output logic            push_ready_o,
  input  logic            pop_i,
  output logic            pop_valid_o,
  output sha1d_pkg::ent_t pop_data_o
);
  import sha1d_pkg::*;

  localparam logic [QAw:0] QCountMax = (QAw + 1)'(QDepth);

  ent_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAw:0]     cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != QCountMax);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Write the entry at the tail
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCountMax)
    else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/sha1d_core.sv
// SHA-1 compression engine: one round per cycle, rolling 16-word schedule.
`default_nettype none

module sha1d_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha1d_pkg::core_ctrl_t ctrl_i,
  input  sha1d_pkg::blk_t       blk_i,
  output sha1d_pkg::core_stat_t stat_o
);
  import sha1d_pkg::*;

  core_st_e   st_q, st_d;
  logic [6:0] rnd_q;
  word_t      a_q, b_q, c_q, d_q, e_q;
  chain_t     h_q;
  blk_t       w_q;
  word_t      f, k, t, w_mix, w_next;

  // Round function and schedule expansion
  always_comb begin
    if (rnd_q inside {[7'd0:7'd19]}) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K0;
    end else if (rnd_q inside {[7'd20:7'd39]}) begin
      f = b_q ^ c_q ^ d_q;
      k = K1;
    end else if (rnd_q inside {[7'd40:7'd59]}) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K3;
    end
    t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
    w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_next = {w_mix[30:0], w_mix[31]};
  end

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      CS_IDLE: begin
        if (ctrl_i.start) begin
          st_d = CS_RUN;
        end
      end
      CS_RUN: begin
        if (rnd_q == LastRound) begin
          st_d = CS_ADD;
        end
      end
      CS_ADD: begin
        st_d = CS_IDLE;
      end
      default: begin
        st_d = CS_IDLE;
      end
    endcase
  end

  // Status outputs
  always_comb begin
    stat_o.busy  = (st_q != CS_IDLE);
    stat_o.chain = h_q;
  end

  // State and round counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= CS_IDLE;
      rnd_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == CS_IDLE) begin
        rnd_q <= '0;
      end else if (st_q == CS_RUN) begin
        rnd_q <= rnd_q + 1'b1;
      end
    end
  end

  // Working variables and schedule window
  always_ff @(posedge clk_i) begin
    if (st_q == CS_IDLE && ctrl_i.start) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
      w_q <= blk_i;
    end else if (st_q == CS_RUN) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
      w_q <= {w_next, w_q[15:1]};
    end
  end

  // Chaining words: reload the initial value or fold in the round result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= ChainInit;
    end else if (ctrl_i.init) begin
      h_q <= ChainInit;
    end else if (st_q == CS_ADD) begin
      h_q[0] <= h_q[0] + a_q;
      h_q[1] <= h_q[1] + b_q;
      h_q[2] <= h_q[2] + c_q;
      h_q[3] <= h_q[3] + d_q;
      h_q[4] <= h_q[4] + e_q;
    end
  end

`ifndef SYNTHESIS
  a_rnd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == CS_RUN |-> rnd_q <= LastRound)
    else $error("round counter past last round");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.start || ctrl_i.init) |-> st_q == CS_IDLE)
    else $error("core command while compressing");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/sha1d_back.sv
// Block sequencer: packs bytes, pads, drives the compression core, emits the digest.
`default_nettype none

module sha1d_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  sha1d_pkg::ent_t       q_data_i,
  output logic                  q_pop_o,
  output sha1d_pkg::core_ctrl_t core_ctrl_o,
  output sha1d_pkg::blk_t       blk_o,
  input  sha1d_pkg::core_stat_t core_stat_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [31:0]           m_axis_tdata_o,  // [31:0] digest_word
  output logic [2:0]            m_axis_tuser_o,  // [2:0] word_index
  output logic                  m_axis_tlast_o   // last_word
);
  import sha1d_pkg::*;

  back_st_e    st_q, st_d;
  blk_t        blk_q, blk_d;
  logic [5:0]  pos_q, pos_d;
  logic [60:0] len_q, len_d;
  logic        full_q, full_d;
  logic [2:0]  idx_q, idx_d;
  logic        pop, do_pad, do_len, issue, out_beat, out_done;
  logic [63:0] bit_len;

  assign bit_len = {len_q, 3'b000};

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      BS_ABSORB: begin
        if (pop && q_data_i.eom) begin
          st_d = BS_PAD;
        end
      end
      BS_PAD: begin
        if (do_pad) begin
          st_d = BS_LEN;
        end
      end
      BS_LEN: begin
        if (do_len) begin
          st_d = BS_FIN;
        end
      end
      BS_FIN: begin
        if (!full_q && !core_stat_i.busy) begin
          st_d = BS_OUT;
        end
      end
      BS_OUT: begin
        if (out_done) begin
          st_d = BS_ABSORB;
        end
      end
      default: begin
        st_d = BS_ABSORB;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    pop      = (st_q == BS_ABSORB) && q_valid_i && !full_q;
    do_pad   = (st_q == BS_PAD) && !full_q;
    do_len   = (st_q == BS_LEN) && !full_q;
    issue    = full_q && !core_stat_i.busy;
    m_axis_tvalid_o = (st_q == BS_OUT);
    out_beat = m_axis_tvalid_o && m_axis_tready_i;
    out_done = out_beat && (idx_q == LastIdx);
    q_pop_o  = pop;
    core_ctrl_o.start = issue;
    core_ctrl_o.init  = out_done;
  end

  // Digest word select
  always_comb begin
    case (idx_q)
      3'd0:    m_axis_tdata_o = core_stat_i.chain[0];
      3'd1:    m_axis_tdata_o = core_stat_i.chain[1];
      3'd2:    m_axis_tdata_o = core_stat_i.chain[2];
      3'd3:    m_axis_tdata_o = core_stat_i.chain[3];
      3'd4:    m_axis_tdata_o = core_stat_i.chain[4];
      default: m_axis_tdata_o = '0;
    endcase
    m_axis_tuser_o = idx_q;
    m_axis_tlast_o = (idx_q == LastIdx);
  end

  // Block buffer, byte position, length and output index
  always_comb begin
    blk_d  = blk_q;
    pos_d  = pos_q;
    len_d  = len_q;
    full_d = full_q;
    idx_d  = idx_q;
    // hand a full block to the core and start a fresh one
    if (issue) begin
      blk_d  = '0;
      full_d = 1'b0;
    end
    if (pop && q_data_i.has_byte) begin
      blk_d[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] = q_data_i.data;
      pos_d = pos_q + 1'b1;
      len_d = len_q + 1'b1;
      if (pos_q == LastBytePos) begin
        full_d = 1'b1;
      end
    end
    // append the marker byte; close the block if the length does not fit
    if (do_pad) begin
      blk_d[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] = PadByte;
      if (pos_q >= LenBytePos) begin
        full_d = 1'b1;
        pos_d  = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
    if (do_len) begin
      blk_d[14] = bit_len[63:32];
      blk_d[15] = bit_len[31:0];
      full_d    = 1'b1;
    end
    if (out_beat) begin
      idx_d = idx_q + 1'b1;
    end
    // drop back to the empty message
    if (out_done) begin
      idx_d = '0;
      pos_d = '0;
      len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= BS_ABSORB;
      blk_q  <= '0;
      pos_q  <= '0;
      len_q  <= '0;
      full_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      st_q   <= st_d;
      blk_q  <= blk_d;
      pos_q  <= pos_d;
      len_q  <= len_d;
      full_q <= full_d;
      idx_q  <= idx_d;
    end
  end

  assign blk_o = blk_q;

`ifndef SYNTHESIS
  a_out_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !full_q && !core_stat_i.busy)
    else $error("digest shown while a block is pending");
  a_issue_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> core_stat_i.busy && !full_q)
    else $error("core did not take the block");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/sha1_digest.sv
// Top level of the SHA-1 digest block: input stage, queue, sequencer, core.
//
//  channel  dir  tdata               tuser               tlast
//  s_axis   in   [7:0] data_byte     [0] has_byte        end_of_message
//  m_axis   out  [31:0] digest_word  [2:0] word_index    last_word
//
// Byte beats are taken one per cycle into a four-entry queue while it has
// room; the sequencer packs one byte per cycle unless a full block is pending,
// while the core compresses the previous block. Each 64-byte block goes
// through the one-round-per-cycle core as issue, 80 rounds and chaining add,
// so long messages are paced by the core. Closing a message adds padding and
// one or two compressions, then five output beats. Reset loads the initial
// chaining value; no clearing pass. Output stalls hold the digest; the queue
// then fills and the input stage drops tready until the digest has gone out.
`default_nettype none

module sha1_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o    // last_word
);
  import sha1d_pkg::*;

  logic       push, push_ready, q_valid, q_pop;
  ent_t       push_data, q_data;
  core_ctrl_t core_ctrl;
  core_stat_t core_stat;
  blk_t       blk;

  sha1d_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .push_o          (push),
    .push_data_o     (push_data),
    .push_ready_i    (push_ready)
  );

  sha1d_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (q_pop),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_data)
  );

  sha1d_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_data),
    .q_pop_o         (q_pop),
    .core_ctrl_o     (core_ctrl),
    .blk_o           (blk),
    .core_stat_i     (core_stat),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  sha1d_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (core_ctrl),
    .blk_i  (blk),
    .stat_o (core_stat)
  );

endmodule

`default_nettype wire

FILE: tb/tb_sha1_digest.sv
// Self-checking testbench for the sha1_digest byte-stream SHA-1 block.
`default_nettype none

module tb_sha1_digest;
  timeunit 1ns;
  timeprecision 1ps;

  import sha1d_pkg::word_t;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned TailCycles = 200;

  // SHA-1 initial hash value and round constants
  localparam word_t H0 = 32'h67452301;
  localparam word_t H1 = 32'hEFCDAB89;
  localparam word_t H2 = 32'h98BADCFE;
  localparam word_t H3 = 32'h10325476;
  localparam word_t H4 = 32'hC3D2E1F0;
  localparam word_t RoundK0 = 32'h5A827999;
  localparam word_t RoundK1 = 32'h6ED9EBA1;
  localparam word_t RoundK2 = 32'h8F1BBCDC;
  localparam word_t RoundK3 = 32'hCA62C1D6;
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [2:0] FinalWord = 3'd4;

  typedef struct {
    word_t      word;
    logic [2:0] idx;
    logic       last;
  } digest_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_valid = 1'b0;
  logic [7:0]  s_data  = 8'h00;
  logic        s_user  = 1'b0;
  logic        s_last  = 1'b0;
  logic        m_ready = 1'b0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // Predictor state: chaining value, open block, fill level, message length
  word_t       hash_state[5];
  word_t       open_block[16];
  logic [5:0]  block_fill;
  logic [60:0] msg_len;

  digest_beat_t digest_q[$];
  int unsigned  n_err     = 0;
  int unsigned  sent_items = 0;
  int unsigned  cyc_cnt   = 0;
  int unsigned  stall_left = 0;
  bit           quiet     = 1'b0;

  sha1_digest DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) cyc_cnt <= cyc_cnt + 1;

  // Abort a hung run
  initial begin
    wait (cyc_cnt >= CycleLimit);
    $display("FAIL sha1_digest");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Digest predictor
  // ---------------------------------------------------------------------------

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void hash_reset();
    hash_state[0] = H0;
    hash_state[1] = H1;
    hash_state[2] = H2;
    hash_state[3] = H3;
    hash_state[4] = H4;
    foreach (open_block[i]) open_block[i] = '0;
    block_fill = '0;
    msg_len    = '0;
  endfunction

  // Run 80 rounds over the open block, fold into the chaining value, clear it
  function automatic void compress_block();
    word_t sched[80];
    word_t a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) sched[i] = open_block[i];
    for (int i = 16; i < 80; i++)
      sched[i] = rotl(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = RoundK0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = RoundK1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RoundK2;
      end else begin
        f = b ^ c ^ d;
        k = RoundK3;
      end
      t = rotl(a, 5) + f + e + k + sched[i];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
    foreach (open_block[i]) open_block[i] = '0;
  endfunction

  // Place one byte big-endian in the open block; compress once it is full
  function automatic void absorb_byte(logic [7:0] v);
    logic [5:0] pos;
    pos = block_fill;
    open_block[pos[5:2]] |= word_t'(v) << ((3 - pos[1:0]) * 8);
    block_fill = pos + 6'd1;
    if (block_fill == 6'd0) compress_block();
  endfunction

  // Apply one accepted input beat; queue the five digest words on a close
  function automatic void predict_beat(logic [7:0] dat, logic hb, logic eom);
    logic [63:0]  bit_len;
    digest_beat_t beat;
    if (hb) begin
      absorb_byte(dat);
      msg_len = msg_len + 61'd1;
    end
    if (!eom) return;
    bit_len = {msg_len, 3'b000};
    absorb_byte(PadMark);
    // no room for the length field: close this block first
    if (block_fill > 6'd56 || block_fill == 6'd0) begin
      if (block_fill != 6'd0) compress_block();
      block_fill = '0;
    end
    open_block[14] = bit_len[63:32];
    open_block[15] = bit_len[31:0];
    compress_block();
    for (int i = 0; i < 5; i++) begin
      beat.word = hash_state[i];
      beat.idx  = 3'(i);
      beat.last = (3'(i) == FinalWord);
      digest_q.insert(digest_q.size(), beat);
    end
    hash_reset();
  endfunction

  // ---------------------------------------------------------------------------
  // Digest checker and output stall generator
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : digest_check
    digest_beat_t want;
    if (m_axis_tvalid_o && m_ready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest beat: word %h index %0d last %0b",
               m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        n_err++;
      end else begin
        want = digest_q.pop_front();
        if (m_axis_tdata_o !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, m_axis_tdata_o);
          n_err++;
        end
        if (m_axis_tuser_o !== want.idx) begin
          $error("word_index: expected %0d, got %0d", want.idx, m_axis_tuser_o);
          n_err++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last_word: expected %0b, got %0b", want.last, m_axis_tlast_o);
          n_err++;
        end
      end
    end
    // hold off the output in short random bursts
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Drive one input beat, wait for its handshake, then predict it
  task automatic send_beat(input logic [7:0] dat, input logic hb, input logic eom);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= dat;
    s_user  <= hb;
    s_last  <= eom;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_beat(dat, hb, eom);
    if (hb || eom) sent_items++;
  endtask

  // Stop sending until every queued digest word has come out
  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  // Send a random message; close it on the last byte or with a bare end beat
  task automatic send_message(input int unsigned len, input bit with_noise);
    bit merge;
    merge = (len != 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if (with_noise && $urandom_range(0, 15) == 0)
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(8'($urandom_range(0, 255)), 1'b1, merge && (i == len - 1));
    end
    if (!merge) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Empty message: a bare end beat, its data byte ignored
  task automatic test_empty_message();
    send_beat(8'hFF, 1'b0, 1'b1);
  endtask

  // "abc", closed on the last byte
  task automatic test_abc();
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
  endtask

  // Extreme bytes, an empty beat and an ignored byte before a separate end
  task automatic test_separate_end();
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'hA5, 1'b0, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
  endtask

  // One-byte messages back to back: the state must restart after a digest
  task automatic test_back_to_back();
    send_beat(8'hFF, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'h80, 1'b1, 1'b1);
  endtask

  // Random messages, weighted toward the padding boundaries
  task automatic test_random_messages(input int unsigned target);
    int unsigned boundary_len[8] = '{55, 56, 57, 63, 64, 65, 119, 120};
    int unsigned start;
    int unsigned len;
    int unsigned room;
    start = sent_items;
    while (sent_items - start < target) begin
      case ($urandom_range(0, 2))
        0:       len = $urandom_range(0, 8);
        1:       len = boundary_len[$urandom_range(0, 7)];
        default: len = $urandom_range(9, 48);
      endcase
      // trim the last message so the item count lands on the target
      room = target - (sent_items - start);
      if (len + 1 > room) len = room - 1;
      send_message(len, 1'b1);
      if (!quiet && $urandom_range(0, 5) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    hash_reset();
    @(posedge clk_i);

    test_empty_message();
    test_abc();
    test_separate_end();
    wait_drained();
    test_back_to_back();
    test_random_messages(270);
    quiet = 1'b1;
    test_random_messages(30);

    // Drain the remaining digests, then watch for stray beats
    s_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (n_err == 0 && digest_q.size() == 0) begin
      $display("PASS sha1_digest");
    end else begin
      $display("FAIL sha1_digest");
    end
    $finish;
  end

endmodule

`default_nettype wire
